// ===== rtl/gtof_pkg.sv =====
// Shared constants, codes and types of the GPS track outlier filter.
package gtof_pkg;

	localparam int LAT_W          = 31;
	localparam int LON_W          = 32;
	localparam int ZB_W           = 31;
	localparam int SIG_W          = 8;
	localparam int CNT_CFG_W      = 7;
	localparam int CFG_DATA_W     = 31;
	localparam int DSUM_W         = 40;
	localparam int SQ_W           = 64;
	localparam int ROOT_W         = 32;
	localparam int MOP_W          = 40;
	localparam int PROD_W         = 80;
	localparam int TH_W           = 40;
	localparam int PT_W           = LAT_W + LON_W;
	localparam int MAX_POINTS_DEF = 64;

	localparam logic [ZB_W-1:0]      ZERO_BAND_RST   = ZB_W'(1000000);
	localparam logic [SIG_W-1:0]     SIGMA_RST       = SIG_W'(56);
	localparam logic [CNT_CFG_W-1:0] MIN_CLUSTER_RST = CNT_CFG_W'(5);
	localparam logic [CNT_CFG_W-1:0] SHORT_LIST_RST  = CNT_CFG_W'(5);

	typedef enum logic [1:0] {
		CFG_ZERO_BAND   = 2'd0,
		CFG_SIGMA       = 2'd1,
		CFG_MIN_CLUSTER = 2'd2,
		CFG_SHORT_LIST  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		STAT_FILTERED = 2'd0,
		STAT_SHORT    = 2'd1,
		STAT_EMPTY    = 2'd2,
		STAT_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} md_op_t;

	typedef struct packed {
		logic   start;
		md_op_t op;
	} md_cmd_t;

endpackage

// ===== rtl/gtof_fix_if.sv =====
// Input channel carrying one GPS fix per transaction.
interface gtof_fix_if;
	import gtof_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [LAT_W-1:0]  latitude;
	logic signed [LON_W-1:0]  longitude;
	logic                     final_fix;

	modport source(output valid, latitude, longitude, final_fix, input ready);
	modport sink(input valid, latitude, longitude, final_fix, output ready);
endinterface

// ===== rtl/gtof_result_if.sv =====
// Output channel carrying one result item per transaction.
interface gtof_result_if;
	import gtof_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [LAT_W-1:0]  kept_latitude;
	logic signed [LON_W-1:0]  kept_longitude;
	logic                     point_valid;
	status_t                  status;
	logic                     end_of_list;

	modport source(output valid, kept_latitude, kept_longitude, point_valid, status,
		end_of_list, input ready);
	modport sink(input valid, kept_latitude, kept_longitude, point_valid, status,
		end_of_list, output ready);
endinterface

// ===== rtl/gtof_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gtof_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/gtof_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
module gtof_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [gtof_pkg::SQ_W-1:0]   value,
	output logic                        done,
	output logic [gtof_pkg::ROOT_W-1:0] root
);
	import gtof_pkg::*;

	logic [SQ_W-1:0] v_q;
	logic [SQ_W-1:0] r_q;
	logic [SQ_W-1:0] bit_q;
	logic            busy_q;
	logic            done_q;
	logic [SQ_W-1:0] trial;

	assign trial = r_q + bit_q;
	assign done  = done_q;
	assign root  = r_q[ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= value;
			r_q   <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule

// ===== rtl/gtof_muldiv.sv =====
// Bit-serial shift-add multiplier and restoring divider sharing one accumulator.
module gtof_muldiv #(
	parameter int NW = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gtof_pkg::md_cmd_t           cmd,
	input  logic [gtof_pkg::PROD_W-1:0] opa,
	input  logic [gtof_pkg::MOP_W-1:0]  opb,
	output logic [gtof_pkg::PROD_W-1:0] res,
	output logic                        done
);
	import gtof_pkg::*;

	localparam int CNTW = $clog2(PROD_W + 1);

	logic [PROD_W-1:0] acc_q;
	logic [MOP_W-1:0]  mcand_q;
	logic [MOP_W-1:0]  mplier_q;
	logic [NW-1:0]     dvs_q;
	logic [NW-1:0]     rem_q;
	logic [CNTW-1:0]   cnt_q;
	md_op_t            op_q;
	logic              busy_q;
	logic              done_q;
	logic [NW:0]       shifted;
	logic              qbit;

	assign shifted = {rem_q, acc_q[PROD_W-1]};
	assign qbit    = (shifted >= {1'b0, dvs_q});
	assign res     = acc_q;
	assign done    = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (cmd.op == OP_MUL) ? CNTW'(MOP_W) : CNTW'(PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q     <= cmd.op;
			mcand_q  <= opa[MOP_W-1:0];
			mplier_q <= opb;
			dvs_q    <= opb[NW-1:0];
			rem_q    <= '0;
			acc_q    <= (cmd.op == OP_MUL) ? '0 : opa;
		end else if (busy_q) begin
			unique case (op_q)
				OP_MUL: begin
					acc_q    <= (acc_q << 1) +
						(mplier_q[MOP_W-1] ? PROD_W'(mcand_q) : '0);
					mplier_q <= mplier_q << 1;
				end
				OP_DIV: begin
					rem_q <= qbit ? NW'(shifted - {1'b0, dvs_q}) : shifted[NW-1:0];
					acc_q <= {acc_q[PROD_W-2:0], qbit};
				end
			endcase
		end
	end
endmodule

// ===== rtl/gps_track_outlier_filter_unit.sv =====
// Top level of the GPS track outlier filter.
//
// Usage: fixes arrive one per transaction on the fix channel; the fix with
// final_fix set closes the track. Non-final fixes produce no result. After
// the closing fix the block streams its results on the result channel, the
// last one flagged end_of_list, then clears the track and takes fixes again.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
//
// Processing: a dropped fix or the first kept fix needs no arithmetic. Every
// other kept fix runs two bit-serial squares and a square root, each with
// a start and a finish. The end of track runs three serial divisions, two
// multiplications and a square root, then two passes over the stored steps,
// one stored step at a time, and emits each kept fix with a handshake.
//
// Reset clears the track and loads the default configuration; the fix and
// step stores are not cleared. A stalled receiver holds the current result
// in the output register; fix.ready stays low until the track is drained.
module gps_track_outlier_filter_unit #(
	parameter int MAX_POINTS = gtof_pkg::MAX_POINTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  gtof_pkg::cfg_idx_t              cfg_index,
	input  logic [gtof_pkg::CFG_DATA_W-1:0] cfg_data,
	gtof_fix_if.sink                        fix,
	gtof_result_if.source                   result
);
	import gtof_pkg::*;

	localparam int AW   = $clog2(MAX_POINTS);
	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int LENW = (CW + 1 > CNT_CFG_W) ? CW + 1 : CNT_CFG_W;

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_SQ1, S_SQ2, S_ROOT, S_NEXT,
		S_FIN, S_MEAN, S_SQS, S_SQN, S_VAR, S_SD, S_TH,
		S_P1_RD, S_P1_EV, S_P2_RD, S_P2_EV,
		S_PT_RD, S_PT_EV, S_PT_OUT, S_LAST_OUT, S_CLEAR
	} state_t;

	state_t state_q;

	// configuration registers
	logic [ZB_W-1:0]      zb_q;
	logic [SIG_W-1:0]     sig_q;
	logic [CNT_CFG_W-1:0] minc_q;
	logic [CNT_CFG_W-1:0] shortl_q;

	// current fix and track state
	logic signed [LAT_W-1:0] cur_lat_q;
	logic signed [LON_W-1:0] cur_lon_q;
	logic                    cur_final_q;
	logic signed [LAT_W-1:0] prev_lat_q;
	logic signed [LON_W-1:0] prev_lon_q;
	logic [CW-1:0]           kept_q;
	logic [DSUM_W-1:0]       dsum_q;
	logic [SQ_W-1:0]         dsq_q;
	logic                    ovf_q;
	logic [ROOT_W-1:0]       dn_q;
	logic [SQ_W-1:0]         sq_q;

	// store write side
	logic              pt_we_q;
	logic [AW-1:0]     pt_waddr_q;
	logic [PT_W-1:0]   pt_wdata_q;
	logic              dist_we_q;
	logic [AW-1:0]     dist_waddr_q;
	logic [ROOT_W-1:0] dist_wdata_q;
	logic [PT_W-1:0]   pt_rd;
	logic [ROOT_W-1:0] dist_rd;

	// arithmetic units
	md_cmd_t           md_cmd_q;
	logic [PROD_W-1:0] md_a_q;
	logic [MOP_W-1:0]  md_b_q;
	logic [PROD_W-1:0] md_res;
	logic              md_done;
	logic              sq_start_q;
	logic [SQ_W-1:0]   sq_v_q;
	logic              sq_done;
	logic [ROOT_W-1:0] sq_root;

	// end of track
	logic [CW-1:0]     n_q;
	logic [ROOT_W-1:0] mean_q;
	logic [TH_W-1:0]   th_q;
	logic              short_q;
	logic [CW-1:0]     i_q;
	logic [CW-1:0]     start_q;
	logic [CW-1:0]     j_q;
	logic [CW-1:0]     last_q;
	logic              found_q;

	// output register
	logic                    out_valid_q;
	logic signed [LAT_W-1:0] out_lat_q;
	logic signed [LON_W-1:0] out_lon_q;
	logic                    out_pv_q;
	status_t                 out_stat_q;
	logic                    out_eol_q;

	// filter and step logic
	logic [LAT_W-1:0]        abs_lat;
	logic [LON_W-1:0]        abs_lon;
	logic                    drop;
	logic signed [LAT_W:0]   dlat_s;
	logic signed [LON_W:0]   dlon_s;
	logic [MOP_W-1:0]        abs_dl;
	logic [ROOT_W-1:0]       abs_dn;
	logic [CW-1:0]           kept_m1;
	logic [SQ_W:0]           sq_sum;
	logic [DSUM_W:0]         dsum_add;
	logic [SQ_W:0]           dsq_add;
	logic [SQ_W-1:0]         diff;
	logic                    is_last;
	logic                    run_end;
	logic [LENW-1:0]         run_len;
	logic                    run_ok;
	logic                    keep_run;
	logic                    fix_acc;
	logic                    res_acc;

	assign fix_acc = fix.valid && fix.ready;
	assign res_acc = result.valid && result.ready;

	assign abs_lat = cur_lat_q[LAT_W-1] ? LAT_W'(-cur_lat_q) : LAT_W'(cur_lat_q);
	assign abs_lon = cur_lon_q[LON_W-1] ? LON_W'(-cur_lon_q) : LON_W'(cur_lon_q);
	assign drop    = (abs_lat < zb_q) || (abs_lon < {1'b0, zb_q}) ||
		((cur_lat_q == prev_lat_q) && (cur_lon_q == prev_lon_q));

	assign dlat_s = $signed({cur_lat_q[LAT_W-1], cur_lat_q}) -
		$signed({prev_lat_q[LAT_W-1], prev_lat_q});
	assign dlon_s = $signed({cur_lon_q[LON_W-1], cur_lon_q}) -
		$signed({prev_lon_q[LON_W-1], prev_lon_q});
	assign abs_dl = dlat_s[LAT_W] ? MOP_W'(-dlat_s) : MOP_W'(dlat_s);
	assign abs_dn = dlon_s[LON_W] ? ROOT_W'(-dlon_s) : ROOT_W'(dlon_s);

	assign kept_m1  = kept_q - 1'b1;
	assign sq_sum   = {1'b0, sq_q} + {1'b0, md_res[SQ_W-1:0]};
	assign dsum_add = {1'b0, dsum_q} + (DSUM_W + 1)'(sq_root);
	assign dsq_add  = {1'b0, dsq_q} + {1'b0, sq_q};
	assign diff     = (md_res > PROD_W'(dsq_q)) ? '0 : dsq_q - md_res[SQ_W-1:0];

	// run boundaries: the last step, or a step above threshold unless the list is short, ends a run
	assign is_last  = (i_q == kept_m1);
	assign run_end  = is_last || (!short_q && (TH_W'(dist_rd) > th_q));
	assign run_len  = LENW'(i_q) - LENW'(start_q) + LENW'(1);
	assign run_ok   = short_q || (run_len >= LENW'(minc_q));
	assign keep_run = run_end && run_ok;

	gtof_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
		.clk   (clk),
		.we    (pt_we_q),
		.waddr (pt_waddr_q),
		.wdata (pt_wdata_q),
		.raddr (j_q[AW-1:0]),
		.rdata (pt_rd)
	);

	gtof_ram #(.WIDTH(ROOT_W), .DEPTH(MAX_POINTS)) u_dist_ram (
		.clk   (clk),
		.we    (dist_we_q),
		.waddr (dist_waddr_q),
		.wdata (dist_wdata_q),
		.raddr (i_q[AW-1:0]),
		.rdata (dist_rd)
	);

	gtof_muldiv #(.NW(CW)) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (md_cmd_q),
		.opa    (md_a_q),
		.opb    (md_b_q),
		.res    (md_res),
		.done   (md_done)
	);

	gtof_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start_q),
		.value  (sq_v_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	assign fix.ready             = (state_q == S_IDLE);
	assign result.valid          = out_valid_q;
	assign result.kept_latitude  = out_lat_q;
	assign result.kept_longitude = out_lon_q;
	assign result.point_valid    = out_pv_q;
	assign result.status         = out_stat_q;
	assign result.end_of_list    = out_eol_q;

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zb_q     <= ZERO_BAND_RST;
			sig_q    <= SIGMA_RST;
			minc_q   <= MIN_CLUSTER_RST;
			shortl_q <= SHORT_LIST_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ZERO_BAND:   zb_q     <= cfg_data[ZB_W-1:0];
				CFG_SIGMA:       sig_q    <= cfg_data[SIG_W-1:0];
				CFG_MIN_CLUSTER: minc_q   <= cfg_data[CNT_CFG_W-1:0];
				CFG_SHORT_LIST:  shortl_q <= cfg_data[CNT_CFG_W-1:0];
			endcase
		end
	end

	// sequencer: load, statistics, two scan passes and output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kept_q      <= '0;
			prev_lat_q  <= '0;
			prev_lon_q  <= '0;
			dsum_q      <= '0;
			dsq_q       <= '0;
			ovf_q       <= 1'b0;
			pt_we_q     <= 1'b0;
			dist_we_q   <= 1'b0;
			md_cmd_q    <= '{start: 1'b0, op: OP_MUL};
			sq_start_q  <= 1'b0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			short_q     <= 1'b0;
		end else begin
			pt_we_q        <= 1'b0;
			dist_we_q      <= 1'b0;
			md_cmd_q.start <= 1'b0;
			sq_start_q     <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (fix_acc) begin
						cur_lat_q   <= fix.latitude;
						cur_lon_q   <= fix.longitude;
						cur_final_q <= fix.final_fix;
						state_q     <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (drop) begin
						state_q <= S_NEXT;
					end else if (kept_q == CW'(MAX_POINTS)) begin
						// no room: flag and keep tracking the fix
						ovf_q      <= 1'b1;
						prev_lat_q <= cur_lat_q;
						prev_lon_q <= cur_lon_q;
						state_q    <= S_NEXT;
					end else if (kept_q == '0) begin
						pt_we_q    <= 1'b1;
						pt_waddr_q <= kept_q[AW-1:0];
						pt_wdata_q <= {cur_lat_q, cur_lon_q};
						kept_q     <= kept_q + 1'b1;
						prev_lat_q <= cur_lat_q;
						prev_lon_q <= cur_lon_q;
						state_q    <= S_NEXT;
					end else begin
						dn_q     <= abs_dn;
						md_cmd_q <= '{start: 1'b1, op: OP_MUL};
						md_a_q   <= PROD_W'(abs_dl);
						md_b_q   <= abs_dl;
						state_q  <= S_SQ1;
					end
				end
				S_SQ1: begin
					if (md_done) begin
						sq_q     <= md_res[SQ_W-1:0];
						md_cmd_q <= '{start: 1'b1, op: OP_MUL};
						md_a_q   <= PROD_W'(dn_q);
						md_b_q   <= MOP_W'(dn_q);
						state_q  <= S_SQ2;
					end
				end
				S_SQ2: begin
					if (md_done) begin
						// saturate the squared step at 64 bits
						if (sq_sum[SQ_W]) begin
							sq_q   <= '1;
							sq_v_q <= '1;
							ovf_q  <= 1'b1;
						end else begin
							sq_q   <= sq_sum[SQ_W-1:0];
							sq_v_q <= sq_sum[SQ_W-1:0];
						end
						sq_start_q <= 1'b1;
						state_q    <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (sq_done) begin
						dist_we_q    <= 1'b1;
						dist_waddr_q <= kept_m1[AW-1:0];
						dist_wdata_q <= sq_root;
						pt_we_q      <= 1'b1;
						pt_waddr_q   <= kept_q[AW-1:0];
						pt_wdata_q   <= {cur_lat_q, cur_lon_q};
						if (dsum_add[DSUM_W]) begin
							dsum_q <= '1;
							ovf_q  <= 1'b1;
						end else begin
							dsum_q <= dsum_add[DSUM_W-1:0];
						end
						if (dsq_add[SQ_W]) begin
							dsq_q <= '1;
							ovf_q <= 1'b1;
						end else begin
							dsq_q <= dsq_add[SQ_W-1:0];
						end
						kept_q     <= kept_q + 1'b1;
						prev_lat_q <= cur_lat_q;
						prev_lon_q <= cur_lon_q;
						state_q    <= S_NEXT;
					end
				end
				S_NEXT: begin
					state_q <= cur_final_q ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					i_q     <= '0;
					start_q <= '0;
					found_q <= 1'b0;
					last_q  <= '0;
					n_q     <= kept_m1;
					th_q    <= '0;
					if (ovf_q || kept_q == '0) begin
						out_valid_q <= 1'b1;
						out_lat_q   <= '0;
						out_lon_q   <= '0;
						out_pv_q    <= 1'b0;
						out_stat_q  <= ovf_q ? STAT_OVERFLOW : STAT_EMPTY;
						out_eol_q   <= 1'b1;
						state_q     <= S_LAST_OUT;
					end else if (LENW'(kept_q) < LENW'(shortl_q)) begin
						short_q <= 1'b1;
						state_q <= S_P1_RD;
					end else begin
						short_q <= 1'b0;
						if (kept_q == CW'(1)) begin
							state_q <= S_P1_RD;
						end else begin
							// mean = dist_sum / n
							md_cmd_q <= '{start: 1'b1, op: OP_DIV};
							md_a_q   <= PROD_W'(dsum_q);
							md_b_q   <= MOP_W'(kept_m1);
							state_q  <= S_MEAN;
						end
					end
				end
				S_MEAN: begin
					if (md_done) begin
						mean_q   <= md_res[ROOT_W-1:0];
						md_cmd_q <= '{start: 1'b1, op: OP_MUL};
						md_a_q   <= PROD_W'(dsum_q);
						md_b_q   <= MOP_W'(dsum_q);
						state_q  <= S_SQS;
					end
				end
				S_SQS: begin
					if (md_done) begin
						md_cmd_q <= '{start: 1'b1, op: OP_DIV};
						md_a_q   <= md_res;
						md_b_q   <= MOP_W'(n_q);
						state_q  <= S_SQN;
					end
				end
				S_SQN: begin
					if (md_done) begin
						// variance numerator, clamped at zero
						md_cmd_q <= '{start: 1'b1, op: OP_DIV};
						md_a_q   <= PROD_W'(diff);
						md_b_q   <= MOP_W'(n_q);
						state_q  <= S_VAR;
					end
				end
				S_VAR: begin
					if (md_done) begin
						sq_v_q     <= md_res[SQ_W-1:0];
						sq_start_q <= 1'b1;
						state_q    <= S_SD;
					end
				end
				S_SD: begin
					if (sq_done) begin
						md_cmd_q <= '{start: 1'b1, op: OP_MUL};
						md_a_q   <= PROD_W'(sq_root);
						md_b_q   <= MOP_W'(sig_q);
						state_q  <= S_TH;
					end
				end
				S_TH: begin
					if (md_done) begin
						th_q    <= TH_W'(mean_q) + TH_W'(md_res[TH_W-1:4]);
						state_q <= S_P1_RD;
					end
				end
				S_P1_RD: begin
					state_q <= S_P1_EV;
				end
				S_P1_EV: begin
					// first pass: find the end of the last run that is emitted
					if (keep_run) begin
						found_q <= 1'b1;
						last_q  <= i_q;
					end
					if (is_last) begin
						i_q     <= '0;
						start_q <= '0;
						if (found_q || keep_run) begin
							state_q <= S_P2_RD;
						end else begin
							out_valid_q <= 1'b1;
							out_lat_q   <= '0;
							out_lon_q   <= '0;
							out_pv_q    <= 1'b0;
							out_stat_q  <= STAT_FILTERED;
							out_eol_q   <= 1'b1;
							state_q     <= S_LAST_OUT;
						end
					end else begin
						if (run_end) begin
							start_q <= i_q + 1'b1;
						end
						i_q     <= i_q + 1'b1;
						state_q <= S_P1_RD;
					end
				end
				S_P2_RD: begin
					state_q <= S_P2_EV;
				end
				S_P2_EV: begin
					if (run_end) begin
						start_q <= i_q + 1'b1;
					end
					if (keep_run) begin
						j_q     <= start_q;
						state_q <= S_PT_RD;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_P2_RD;
					end
				end
				S_PT_RD: begin
					state_q <= S_PT_EV;
				end
				S_PT_EV: begin
					out_valid_q <= 1'b1;
					out_lat_q   <= pt_rd[PT_W-1:LON_W];
					out_lon_q   <= pt_rd[LON_W-1:0];
					out_pv_q    <= 1'b1;
					out_stat_q  <= short_q ? STAT_SHORT : STAT_FILTERED;
					out_eol_q   <= (j_q == last_q);
					state_q     <= S_PT_OUT;
				end
				S_PT_OUT: begin
					if (res_acc) begin
						out_valid_q <= 1'b0;
						if (out_eol_q) begin
							state_q <= S_CLEAR;
						end else if (j_q == i_q) begin
							i_q     <= i_q + 1'b1;
							state_q <= S_P2_RD;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_PT_RD;
						end
					end
				end
				S_LAST_OUT: begin
					if (res_acc) begin
						out_valid_q <= 1'b0;
						state_q     <= S_CLEAR;
					end
				end
				S_CLEAR: begin
					kept_q     <= '0;
					prev_lat_q <= '0;
					prev_lon_q <= '0;
					dsum_q     <= '0;
					dsq_q      <= '0;
					ovf_q      <= 1'b0;
					state_q    <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// no new fix while a result is pending
	a_no_fix_during_output: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !fix.ready)
		else $error("fix channel open while a result is pending");

	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= CW'(MAX_POINTS))
		else $error("kept fix count beyond store depth");

	a_eol_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(res_acc && result.end_of_list) |=> !result.valid)
		else $error("result after end of list");

	a_point_status: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.point_valid) |->
			(result.status == STAT_FILTERED || result.status == STAT_SHORT))
		else $error("fix carried with an error status");

endmodule
